// ----- rtl/core/usv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_pkg
// Constants and helpers shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package usv_pkg;

  // Width of the internal byte counter and offsets; any value from 16 to 64.
  localparam int unsigned OFFSET_BITS  = 32;
  // Width of the reported error offset.
  localparam int unsigned ERR_OFFSET_W = 32;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [1:0]             count_t;

  localparam logic [7:0] ASCII_TOP     = 8'h7F;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  localparam logic [7:0] LEAD_SURR     = 8'hED;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_TAG      = 8'h80;
  localparam logic [5:0] LOW_MASK      = 6'h3F;
  // Limits on the first continuation's payload bits.
  localparam logic [5:0] LIM_OVER3     = 6'h20;
  localparam logic [5:0] LIM_SURR      = 6'h20;
  localparam logic [5:0] LIM_OVER4     = 6'h10;
  localparam logic [5:0] LIM_MAX       = 6'h10;

  // Number of continuation bytes that follow a lead byte.
  function automatic count_t followers_of(input logic [7:0] lead);
    count_t n;
    if (lead < LEAD3_MIN) begin
      n = 2'd1;
    end else if (lead < LEAD4_MIN) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/utf8_stream_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker for a byte stream, reporting the first bad offset.
// ----------------------------------------------------------------------------
// The result for a stream is registered in the cycle after its last item is
// accepted, held in the output register until taken.
// Throughput: one item per cycle unless stalled; the state update per byte sets
// this, and input stalls only while a result waits and the output is stalled.
// Reset: asynchronous, active low; clears all stream state and out_valid_o.
module utf8_stream_validator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              text_valid_o,
  output logic [usv_pkg::ERR_OFFSET_W-1:0]  error_offset_o
);
  import usv_pkg::*;

  offset_t    byte_position_q, byte_position_d;
  offset_t    sequence_start_q, sequence_start_d;
  logic [7:0] lead_value_q, lead_value_d;
  count_t     bytes_expected_q, bytes_expected_d;
  logic       range_fault_q, range_fault_d;
  logic       cont_fault_q, cont_fault_d;
  offset_t    cont_fault_offset_q, cont_fault_offset_d;
  logic       error_found_q, error_found_d;
  offset_t    first_error_offset_q, first_error_offset_d;

  logic                    out_valid_q;
  logic                    text_valid_q;
  logic [ERR_OFFSET_W-1:0] error_offset_q;

  logic       accept;
  logic [5:0] low_bits;
  logic       first_cont;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign low_bits   = data_byte_i[5:0] & LOW_MASK;
  assign first_cont = (bytes_expected_q == followers_of(lead_value_q));

  always_comb begin
    byte_position_d      = byte_position_q + offset_t'(1);
    sequence_start_d     = sequence_start_q;
    lead_value_d         = lead_value_q;
    bytes_expected_d     = bytes_expected_q;
    range_fault_d        = range_fault_q;
    cont_fault_d         = cont_fault_q;
    cont_fault_offset_d  = cont_fault_offset_q;
    error_found_d        = error_found_q;
    first_error_offset_d = first_error_offset_q;

    if (!error_found_q) begin
      if (bytes_expected_q == 2'd0) begin
        if (data_byte_i > ASCII_TOP) begin
          if (data_byte_i inside {[LEAD2_MIN:LEAD4_MAX]}) begin
            bytes_expected_d    = followers_of(data_byte_i);
            sequence_start_d    = byte_position_q;
            lead_value_d        = data_byte_i;
            range_fault_d       = 1'b0;
            cont_fault_d        = 1'b0;
            cont_fault_offset_d = '0;
          end else begin
            error_found_d        = 1'b1;
            first_error_offset_d = byte_position_q;
          end
        end
      end else begin
        if (((data_byte_i & CONT_MASK) != CONT_TAG) && !cont_fault_q) begin
          cont_fault_d        = 1'b1;
          cont_fault_offset_d = byte_position_q;
        end
        // All range limits are decided by the first continuation byte.
        if (first_cont) begin
          if ((lead_value_q == LEAD3_MIN && low_bits <  LIM_OVER3) ||
              (lead_value_q == LEAD_SURR && low_bits >= LIM_SURR)  ||
              (lead_value_q == LEAD4_MIN && low_bits <  LIM_OVER4) ||
              (lead_value_q == LEAD4_MAX && low_bits >= LIM_MAX)) begin
            range_fault_d = 1'b1;
          end
        end
        bytes_expected_d = bytes_expected_q - 2'd1;
        if (bytes_expected_d == 2'd0) begin
          if (cont_fault_d) begin
            error_found_d        = 1'b1;
            first_error_offset_d = cont_fault_offset_d;
          end else if (range_fault_d) begin
            error_found_d        = 1'b1;
            first_error_offset_d = sequence_start_q;
          end
        end
      end
    end

    // A sequence still open at the end of the stream reports its lead.
    if (last_byte_i && !error_found_d && bytes_expected_d != 2'd0) begin
      error_found_d        = 1'b1;
      first_error_offset_d = sequence_start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q      <= '0;
      sequence_start_q     <= '0;
      lead_value_q         <= '0;
      bytes_expected_q     <= '0;
      range_fault_q        <= 1'b0;
      cont_fault_q         <= 1'b0;
      cont_fault_offset_q  <= '0;
      error_found_q        <= 1'b0;
      first_error_offset_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        byte_position_q      <= '0;
        sequence_start_q     <= '0;
        lead_value_q         <= '0;
        bytes_expected_q     <= '0;
        range_fault_q        <= 1'b0;
        cont_fault_q         <= 1'b0;
        cont_fault_offset_q  <= '0;
        error_found_q        <= 1'b0;
        first_error_offset_q <= '0;
      end else begin
        byte_position_q      <= byte_position_d;
        sequence_start_q     <= sequence_start_d;
        lead_value_q         <= lead_value_d;
        bytes_expected_q     <= bytes_expected_d;
        range_fault_q        <= range_fault_d;
        cont_fault_q         <= cont_fault_d;
        cont_fault_offset_q  <= cont_fault_offset_d;
        error_found_q        <= error_found_d;
        first_error_offset_q <= first_error_offset_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      text_valid_q   <= !error_found_d;
      error_offset_q <= error_found_d ? ERR_OFFSET_W'(first_error_offset_d) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign text_valid_o   = text_valid_q;
  assign error_offset_o = error_offset_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream validator. Byte streams are sent
// with random gaps, and each verdict is compared with the one the bench works
// out itself from the accepted bytes. Most streams are well-formed text with
// occasional overlong, surrogate, out-of-range, corrupted and cut-short
// sequences mixed in. The receiver stalls at random and, twice, for a long
// stretch, so that a waiting result holds up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import usv_pkg::*;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned BYTE_TARGET  = 1700;
  localparam int unsigned IDLE_PERCENT = 13;

  typedef struct packed {
    logic                    ok;
    logic [ERR_OFFSET_W-1:0] offset;
  } verdict_t;

  // Works out the verdict of each stream from its accepted bytes and keeps
  // the verdicts that are still due from the block.
  class stream_verdict_tracker;
    offset_t    pos;
    offset_t    seq_start;
    logic [7:0] lead;
    count_t     pending;
    count_t     seq_len;
    logic       range_bad;
    logic       cont_bad;
    offset_t    cont_at;
    logic       err_seen;
    offset_t    err_at;
    verdict_t   verdicts_due[$];
    int         mismatches;

    function void clear_stream();
      pos       = '0;
      seq_start = '0;
      lead      = '0;
      pending   = '0;
      seq_len   = '0;
      range_bad = 1'b0;
      cont_bad  = 1'b0;
      cont_at   = '0;
      err_seen  = 1'b0;
      err_at    = '0;
    endfunction

    function void flag_error(offset_t at);
      err_seen = 1'b1;
      err_at   = at;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [5:0] low;
      count_t     need;
      verdict_t   v;
      low = b[5:0] & LOW_MASK;
      if (!err_seen) begin
        if (pending == 2'd0) begin
          if (b > ASCII_TOP) begin
            if (b >= LEAD2_MIN && b <= LEAD2_MAX) need = 2'd1;
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX) need = 2'd2;
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX) need = 2'd3;
            else need = 2'd0;
            if (need == 2'd0) begin
              flag_error(pos);
            end else begin
              pending   = need;
              seq_len   = need;
              seq_start = pos;
              lead      = b;
              range_bad = 1'b0;
              cont_bad  = 1'b0;
              cont_at   = '0;
            end
          end
        end else begin
          if ((b & CONT_MASK) != CONT_TAG && !cont_bad) begin
            cont_bad = 1'b1;
            cont_at  = pos;
          end
          // Only the first continuation can push the code point out of range.
          if (pending == seq_len) begin
            if ((lead == LEAD3_MIN && low < LIM_OVER3) ||
                (lead == LEAD_SURR && low >= LIM_SURR) ||
                (lead == LEAD4_MIN && low < LIM_OVER4) ||
                (lead == LEAD4_MAX && low >= LIM_MAX)) begin
              range_bad = 1'b1;
            end
          end
          pending = pending - 2'd1;
          if (pending == 2'd0) begin
            if (cont_bad) flag_error(cont_at);
            else if (range_bad) flag_error(seq_start);
          end
        end
      end
      pos = pos + 1'b1;
      if (last) begin
        // A sequence cut short by the end of the stream blames its lead.
        if (!err_seen && pending != 2'd0) flag_error(seq_start);
        v.ok     = !err_seen;
        v.offset = err_seen ? err_at[ERR_OFFSET_W-1:0] : '0;
        verdicts_due.insert(verdicts_due.size(), v);
        clear_stream();
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_verdict(logic ok, logic [ERR_OFFSET_W-1:0] offset);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result with none due: text_valid=%0b error_offset=%0d",
                         ok, offset));
      end else begin
        want = verdicts_due.pop_front();
        if (ok !== want.ok) begin
          report($sformatf("text_valid %0b, expected %0b", ok, want.ok));
        end
        if (offset !== want.offset) begin
          report($sformatf("error_offset %0d, expected %0d", offset, want.offset));
        end
      end
    endtask
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [7:0]              data_byte_i  = 8'h00;
  logic                    last_byte_i  = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic                    text_valid_o;
  logic [ERR_OFFSET_W-1:0] error_offset_o;

  stream_verdict_tracker tracker;
  int unsigned           cycles      = 0;
  int unsigned           bytes_sent  = 0;
  int unsigned           stall_left  = 0;
  logic [7:0]            text_q[$];

  utf8_stream_validator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .text_valid_o   (text_valid_o),
    .error_offset_o (error_offset_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  // Results are checked before the input of the same edge is noted, since a
  // result always belongs to an earlier stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_verdict(text_valid_o, error_offset_o);
      if (in_valid_i && in_ready_o) tracker.note_byte(data_byte_i, last_byte_i);
    end
  end

  // Receiver: random stalls, two long hold-offs and a calm stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (cycles == 300 || cycles == 1100) stall_left = 80;
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!(cycles >= 1400 && cycles < 1900) &&
                   $urandom_range(0, 99) < IDLE_PERCENT) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic calm;
    calm = (bytes_sent >= 700 && bytes_sent < 1000);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  // Adds one byte at the end of the stream being built.
  function automatic void append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Picks an end of the range now and then, so that the boundaries get hit.
  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Encodes a code point in n bytes, whether or not n is the proper length.
  function automatic void push_code(int unsigned cp, int n);
    logic [20:0] c;
    c = cp[20:0];
    case (n)
      1: begin
        append_byte({1'b0, c[6:0]});
      end
      2: begin
        append_byte({3'b110, c[10:6]});
        append_byte({2'b10, c[5:0]});
      end
      3: begin
        append_byte({4'b1110, c[15:12]});
        append_byte({2'b10, c[11:6]});
        append_byte({2'b10, c[5:0]});
      end
      default: begin
        append_byte({5'b11110, c[20:18]});
        append_byte({2'b10, c[17:12]});
        append_byte({2'b10, c[11:6]});
        append_byte({2'b10, c[5:0]});
      end
    endcase
  endfunction

  function automatic void push_random_char();
    int unsigned r;
    int          n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_code(pick(32'h0, 32'h7F), 1);
    end else if (r < 48) begin
      push_code(pick(32'h80, 32'h7FF), 2);
    end else if (r < 68) begin
      if ($urandom_range(0, 1)) push_code(pick(32'h800, 32'hD7FF), 3);
      else push_code(pick(32'hE000, 32'hFFFF), 3);
    end else if (r < 84) begin
      push_code(pick(32'h10000, 32'h10FFFF), 4);
    end else if (r < 89) begin
      // Overlong: a code point that would fit in fewer bytes.
      n = $urandom_range(2, 4);
      if (n == 2) push_code(pick(32'h0, 32'h7F), 2);
      else if (n == 3) push_code(pick(32'h0, 32'h7FF), 3);
      else push_code(pick(32'h0, 32'hFFFF), 4);
    end else if (r < 92) begin
      push_code(pick(32'hD800, 32'hDFFF), 3);
    end else if (r < 95) begin
      push_code(pick(32'h110000, 32'h1FFFFF), 4);
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_random_stream();
    int unsigned chars;
    int unsigned r;
    int unsigned drop;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // Plain noise.
      chars = $urandom_range(1, 10);
      repeat (chars) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    chars = (r < 15) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    repeat (chars) push_random_char();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 20 && text_q.size() > 1) begin
      drop = $urandom_range(1, (text_q.size() > 3) ? 3 : text_q.size() - 1);
      repeat (drop) text_q.delete(text_q.size() - 1);
    end
  endfunction

  initial begin
    tracker = new;
    tracker.clear_stream();
    tracker.mismatches = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Valid text covering every sequence length and the range boundaries.
    text_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
               8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_stream();
    text_q = '{8'hFF};
    send_stream();
    text_q = '{8'hED, 8'hA0, 8'h80};
    send_stream();
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_stream();
    // Bad continuation, then bytes after the error that are only counted.
    text_q = '{8'hC2, 8'h41, 8'h5A};
    send_stream();
    // Cut short with a bad continuation: the lead is still blamed.
    text_q = '{8'hE2, 8'h41};
    send_stream();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_stream();
      send_stream();
    end
    in_valid_i <= 1'b0;

    while (tracker.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycles >= RUN_LIMIT);
    $display("[%0t] run limit reached", $realtime);
    $display("TEST FAILED");
    $finish;
  end

endmodule
